// ===== design/kanji_output_code_converter_top_macros.svh =====
// Assertion macros shared by the converter RTL.
`ifndef KANJI_OUTPUT_CODE_CONVERTER_TOP_MACROS_SVH
`define KANJI_OUTPUT_CODE_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTH
`define KOCC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kocc check failed");
`define KOCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kocc check failed");
`else
`define KOCC_ASSERT_IMP(lbl, ante, cons)
`define KOCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/kocc_pkg.sv =====
package kocc_pkg;

    // output code values
    localparam logic [1:0] OUT_EUC  = 2'd0;
    localparam logic [1:0] OUT_SJIS = 2'd1;
    localparam logic [1:0] OUT_JIS  = 2'd2;

    // internal code values
    localparam logic INT_EUC  = 1'b0;
    localparam logic INT_SJIS = 1'b1;

    // configuration register indexes
    localparam logic REG_OUTPUT_CODE   = 1'b0;
    localparam logic REG_INTERNAL_CODE = 1'b1;

    localparam logic [7:0] CHAR_ESC    = 8'h1B;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_B      = 8'h42;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int BEAT_W      = 2;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_ENTER,
        ESC_LEAVE
    } esc_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_BYTE,
        OP_E2S,
        OP_S2E,
        OP_S2J,
        OP_MASK
    } op_t;

    typedef struct packed {
        esc_t       esc;
        op_t        op;
        logic [7:0] lead;
        logic [7:0] trail;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [15:0] euc_to_sjis(input logic [7:0] a, input logic [7:0] b);
        logic [6:0] h;
        logic [6:0] l;
        logic [6:0] hm1;
        logic [7:0] half;
        logic [7:0] add;
        logic [7:0] ra;
        logic [7:0] rb;
        h    = a[6:0];
        l    = b[6:0];
        hm1  = h - 7'd1;
        half = (h == 7'd0) ? 8'hFF : {2'b00, hm1[6:1]};
        ra   = half + ((h <= 7'h5E) ? 8'h71 : 8'hB1);
        if (h[0])
        begin
            add = (l < 7'h60) ? 8'h1F : 8'h20;
        end
        else
        begin
            add = 8'h7E;
        end
        rb = {1'b0, l} + add;
        return {ra, rb};
    endfunction

    function automatic logic [15:0] sjis_to_euc(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] h;
        logic [7:0] l;
        h = {a[6:0], 1'b0} - ((a <= 8'h9F) ? 8'hE1 : 8'h61);
        if (b < 8'h9F)
        begin
            l = b - ((b > 8'h7F) ? 8'h20 : 8'h1F);
        end
        else
        begin
            l = b - 8'h7E;
            h = h + 8'd1;
        end
        return {h | 8'h80, l | 8'h80};
    endfunction

endpackage

// ===== design/kocc_front.sv =====
module kocc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic [1:0]           output_code,
    input  logic                 internal_code,
    input  kocc_pkg::q_status_t  q_status,
    output logic                 push,
    output kocc_pkg::cmd_t       push_cmd
);

    typedef enum logic [1:0] {
        MODE_ASCII,
        MODE_LEAD,
        MODE_TRAIL
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] held_reg, held_next;
    logic       accept;
    logic       jis;
    kocc_pkg::cmd_t cmd;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && !q_status.full;
    assign jis      = output_code[1];

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        cmd.esc   = kocc_pkg::ESC_NONE;
        cmd.op    = kocc_pkg::OP_NONE;
        cmd.lead  = s_tdata;
        cmd.trail = s_tdata;
        if (s_tdata == 8'h00)
        begin
            // end of text: fall back to ASCII
            if (mode_reg != MODE_ASCII && jis)
            begin
                cmd.esc = kocc_pkg::ESC_LEAVE;
            end
            mode_next = MODE_ASCII;
        end
        else if (output_code == {1'b0, internal_code})
        begin
            cmd.op = kocc_pkg::OP_BYTE;
        end
        else
        begin
            if (mode_reg == MODE_ASCII && s_tdata[7])
            begin
                if (jis)
                begin
                    cmd.esc = kocc_pkg::ESC_ENTER;
                end
                mode_next = MODE_LEAD;
            end
            else if (mode_reg == MODE_LEAD && !s_tdata[7])
            begin
                if (jis)
                begin
                    cmd.esc = kocc_pkg::ESC_LEAVE;
                end
                mode_next = MODE_ASCII;
            end

            case (mode_next)
                MODE_ASCII:
                begin
                    cmd.op = kocc_pkg::OP_BYTE;
                end
                MODE_LEAD:
                begin
                    held_next = s_tdata;
                    mode_next = MODE_TRAIL;
                end
                default:
                begin
                    cmd.lead = held_reg;
                    if (internal_code == kocc_pkg::INT_SJIS)
                    begin
                        cmd.op = jis ? kocc_pkg::OP_S2J : kocc_pkg::OP_S2E;
                    end
                    else if (output_code == kocc_pkg::OUT_SJIS)
                    begin
                        cmd.op = kocc_pkg::OP_E2S;
                    end
                    else
                    begin
                        cmd.op = kocc_pkg::OP_MASK;
                    end
                    mode_next = MODE_LEAD;
                end
            endcase
        end
    end

    // only items that give bytes go to the back
    assign push     = accept && (cmd.esc != kocc_pkg::ESC_NONE || cmd.op != kocc_pkg::OP_NONE);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ASCII;
            held_reg <= 8'h00;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

endmodule

// ===== design/kocc_queue.sv =====
module kocc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  kocc_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output kocc_pkg::cmd_t      head_cmd,
    output kocc_pkg::q_status_t status
);

    kocc_pkg::cmd_t                  mem_reg [kocc_pkg::QUEUE_DEPTH];
    logic [kocc_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [kocc_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [kocc_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign status.full  = (count_reg == kocc_pkg::QCNT_W'(kocc_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_cmd     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == kocc_pkg::QPTR_W'(kocc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == kocc_pkg::QPTR_W'(kocc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/kocc_back.sv =====
module kocc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  kocc_pkg::cmd_t      head_cmd,
    input  kocc_pkg::q_status_t q_status,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);

    logic [kocc_pkg::BEAT_W-1:0] beat_reg, beat_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;
    logic                        load;
    logic                        has_esc;
    logic [kocc_pkg::BEAT_W:0]   n_beats;
    logic                        is_last;
    logic [15:0]                 pair;
    logic [7:0]                  d0;
    logic [7:0]                  d1;
    logic [7:0]                  esc_mid;
    logic [7:0]                  beat_byte;

    assign has_esc = (head_cmd.esc != kocc_pkg::ESC_NONE);
    assign esc_mid = (head_cmd.esc == kocc_pkg::ESC_ENTER) ?
                     kocc_pkg::CHAR_DOLLAR : kocc_pkg::CHAR_LPAREN;

    // convert the pair
    always_comb
    begin
        pair = {head_cmd.lead, head_cmd.trail};
        case (head_cmd.op)
            kocc_pkg::OP_E2S: pair = kocc_pkg::euc_to_sjis(head_cmd.lead, head_cmd.trail);
            kocc_pkg::OP_S2E: pair = kocc_pkg::sjis_to_euc(head_cmd.lead, head_cmd.trail);
            kocc_pkg::OP_S2J: pair = kocc_pkg::sjis_to_euc(head_cmd.lead, head_cmd.trail)
                                     & 16'h7F7F;
            kocc_pkg::OP_MASK: pair = {head_cmd.lead, head_cmd.trail} & 16'h7F7F;
            default: pair = {head_cmd.lead, head_cmd.trail};
        endcase
        d0 = pair[15:8];
        d1 = pair[7:0];
    end

    always_comb
    begin
        n_beats = has_esc ? 3'd3 : 3'd0;
        case (head_cmd.op)
            kocc_pkg::OP_NONE: n_beats = n_beats;
            kocc_pkg::OP_BYTE: n_beats = n_beats + 3'd1;
            default:           n_beats = n_beats + 3'd2;
        endcase
        is_last = ({1'b0, beat_reg} == n_beats - 3'd1);
    end

    always_comb
    begin
        beat_byte = d0;
        if (has_esc)
        begin
            case (beat_reg)
                2'd0:    beat_byte = kocc_pkg::CHAR_ESC;
                2'd1:    beat_byte = esc_mid;
                2'd2:    beat_byte = kocc_pkg::CHAR_B;
                default: beat_byte = d0;
            endcase
        end
        else
        begin
            beat_byte = beat_reg[0] ? d1 : d0;
        end
    end

    // load a beat whenever the queue holds a command and the output register is free or drains
    assign load = !q_status.empty && (!out_valid_reg || m_tready);
    assign pop  = load && is_last;

    always_comb
    begin
        beat_next      = beat_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = beat_byte;
            out_last_next  = is_last;
            beat_next      = is_last ? '0 : beat_reg + 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg      <= beat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/kanji_output_code_converter_top.sv =====
// Channel   Direction  Signals                      Content
// s_*       in         s_tvalid s_tready s_tdata    text byte in the internal code
// m_*       out        m_tvalid m_tready m_tdata    converted byte, m_tlast ends its group
// cfg_*     in         cfg_we cfg_index cfg_data    output_code (0), internal_code (1)
//
// One input beat is taken per cycle while the command queue has room; the
// classifier updates the shift state as each byte is taken.
// The back end sends one output beat per cycle unless the queue is empty or
// m_tready stalls it; an input byte makes 0 to 4 beats, escape sequences included.
// Reset clears the shift state, held lead byte, queue and output valid flag.
// A stall on m_tready fills the queue, then drops s_tready; the front and
// the back otherwise stall on their own.
`include "kanji_output_code_converter_top_macros.svh"

module kanji_output_code_converter_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [1:0] cfg_data
);

    logic [1:0]          output_code_reg;
    logic                internal_code_reg;
    logic                push;
    logic                pop;
    kocc_pkg::cmd_t      push_cmd;
    kocc_pkg::cmd_t      head_cmd;
    kocc_pkg::q_status_t q_status;

    // configuration registers; the user writes them only while idle, which the block does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_code_reg   <= kocc_pkg::OUT_EUC;
            internal_code_reg <= kocc_pkg::INT_EUC;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kocc_pkg::REG_OUTPUT_CODE:   output_code_reg   <= cfg_data;
                kocc_pkg::REG_INTERNAL_CODE: internal_code_reg <= cfg_data[0];
                default:                     output_code_reg   <= output_code_reg;
            endcase
        end
    end

    // classify bytes and track the shift mode
    kocc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .output_code   (output_code_reg),
        .internal_code (internal_code_reg),
        .q_status      (q_status),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    // hold commands between the two halves
    kocc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // convert pairs and emit escapes and data one beat at a time
    kocc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // a group that is not finished keeps its command at the queue head
    `KOCC_ASSERT_NEXT(a_group_continues, m_tvalid && m_tready && !m_tlast, m_tvalid)
    // seven-bit output never carries a high bit
    `KOCC_ASSERT_IMP(a_jis_seven_bit, m_tvalid && output_code_reg[1], !m_tdata[7])
    // the front never pushes into a full queue
    `KOCC_ASSERT_IMP(a_no_overflow, push, !q_status.full && s_tvalid)

endmodule
